### rtl/tinv_pkg.sv
// Shared types and constants for the 3x3 tensor invariants pipeline.
package tinv_pkg;

    // Number of register stages from the input ports to the output registers.
    localparam int NUM_STAGES = 6;

    // Per-stage load strobes from the pipeline control to the datapaths.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } tinv_adv_t;

endpackage

### rtl/tinv_ctrl.sv
// Valid/ready control for the invariants pipeline: stage valid bits and load strobes.
module tinv_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output tinv_pkg::tinv_adv_t adv
);
    import tinv_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;

    // A stage can take a new transaction when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // Load strobes and next valid bits; bubbles are squeezed out on a stall.
    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (k == 0)
            begin
                adv.load[k]   = stage_ready[k] && in_valid;
                valid_next[k] = stage_ready[k] ? in_valid : valid_reg[k];
            end
            else
            begin
                adv.load[k]   = stage_ready[k] && valid_reg[k-1];
                valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

### rtl/tinv_det.sv
// Determinant datapath: 2x2 minors, cofactor products, sum, rounding and saturation.
module tinv_det #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                          clk,
    input  tinv_pkg::tinv_adv_t           adv,
    input  logic signed [DATA_WIDTH-1:0]  a00,
    input  logic signed [DATA_WIDTH-1:0]  a01,
    input  logic signed [DATA_WIDTH-1:0]  a02,
    input  logic signed [DATA_WIDTH-1:0]  a10,
    input  logic signed [DATA_WIDTH-1:0]  a11,
    input  logic signed [DATA_WIDTH-1:0]  a12,
    input  logic signed [DATA_WIDTH-1:0]  a20,
    input  logic signed [DATA_WIDTH-1:0]  a21,
    input  logic signed [DATA_WIDTH-1:0]  a22,
    output logic signed [DATA_WIDTH-1:0]  det_out,
    output logic                          det_sat
);
    import tinv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;       // element product
    localparam int MW  = 2 * W + 1;   // minor
    localparam int LW  = 2 * W + 1;   // element times half a minor
    localparam int DW  = 3 * W + 3;   // full determinant
    localparam int RS  = 2 * FRAC_BITS;
    localparam logic [DW-1:0] HALF = (DW'(1) << RS) >> 1;
    localparam logic [W-1:0]  MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MIN_VAL = {1'b1, {(W-1){1'b0}}};

    // Stage 0: the six products that form the minors of row 0.
    logic signed [PW-1:0] p48_reg, p57_reg, p38_reg, p56_reg, p37_reg, p46_reg;
    logic signed [W-1:0]  r0_s0_reg, r1_s0_reg, r2_s0_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            p48_reg   <= PW'(a11) * PW'(a22);
            p57_reg   <= PW'(a12) * PW'(a21);
            p38_reg   <= PW'(a10) * PW'(a22);
            p56_reg   <= PW'(a12) * PW'(a20);
            p37_reg   <= PW'(a10) * PW'(a21);
            p46_reg   <= PW'(a11) * PW'(a20);
            r0_s0_reg <= a00;
            r1_s0_reg <= a01;
            r2_s0_reg <= a02;
        end
    end

    // Stage 1: the three minors.
    logic signed [MW-1:0] m0_reg, m1_reg, m2_reg;
    logic signed [W-1:0]  r0_s1_reg, r1_s1_reg, r2_s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load[1])
        begin
            m0_reg    <= MW'(p48_reg) - MW'(p57_reg);
            m1_reg    <= MW'(p38_reg) - MW'(p56_reg);
            m2_reg    <= MW'(p37_reg) - MW'(p46_reg);
            r0_s1_reg <= r0_s0_reg;
            r1_s1_reg <= r1_s0_reg;
            r2_s1_reg <= r2_s0_reg;
        end
    end

    // Stage 2: each minor is split into a low unsigned half and a high signed half,
    // so every multiplier stays about one word by one word.
    logic signed [W:0]    ml0, ml1, ml2;
    logic signed [W:0]    mh0, mh1, mh2;
    logic signed [LW-1:0] pl0_reg, pl1_reg, pl2_reg;
    logic signed [LW-1:0] ph0_reg, ph1_reg, ph2_reg;

    always_comb
    begin
        ml0 = $signed({1'b0, m0_reg[W-1:0]});
        ml1 = $signed({1'b0, m1_reg[W-1:0]});
        ml2 = $signed({1'b0, m2_reg[W-1:0]});
        mh0 = $signed(m0_reg[MW-1:W]);
        mh1 = $signed(m1_reg[MW-1:W]);
        mh2 = $signed(m2_reg[MW-1:W]);
    end

    always_ff @(posedge clk)
    begin
        if (adv.load[2])
        begin
            pl0_reg <= LW'(r0_s1_reg) * LW'(ml0);
            pl1_reg <= LW'(r1_s1_reg) * LW'(ml1);
            pl2_reg <= LW'(r2_s1_reg) * LW'(ml2);
            ph0_reg <= LW'(r0_s1_reg) * LW'(mh0);
            ph1_reg <= LW'(r1_s1_reg) * LW'(mh1);
            ph2_reg <= LW'(r2_s1_reg) * LW'(mh2);
        end
    end

    // Stage 3: recombine the halves and sum the cofactor terms with alternating sign.
    logic signed [DW-1:0] term0, term1, term2, det_next;
    logic signed [DW-1:0] det_reg;

    always_comb
    begin
        term0    = (DW'(ph0_reg) <<< W) + DW'(pl0_reg);
        term1    = (DW'(ph1_reg) <<< W) + DW'(pl1_reg);
        term2    = (DW'(ph2_reg) <<< W) + DW'(pl2_reg);
        det_next = term0 - term1 + term2;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load[3])
        begin
            det_reg <= det_next;
        end
    end

    // Stage 4: sign and magnitude, so rounding is symmetric about zero.
    logic          neg_reg;
    logic [DW-1:0] mag_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load[4])
        begin
            neg_reg <= det_reg[DW-1];
            mag_reg <= det_reg[DW-1] ? $unsigned(-det_reg) : $unsigned(det_reg);
        end
    end

    // Stage 5: round half away from zero, restore the sign, saturate.
    logic [DW-1:0] rnd;
    logic [W-1:0]  rnd_lo;
    logic          sat;
    logic [W-1:0]  det_next_out;
    logic [W-1:0]  det_out_reg;
    logic          det_sat_reg;

    always_comb
    begin
        rnd    = (mag_reg + HALF) >> RS;
        rnd_lo = rnd[W-1:0];
        if (neg_reg)
        begin
            sat = (|rnd[DW-1:W]) || (rnd[W-1] && (|rnd[W-2:0]));
        end
        else
        begin
            sat = |rnd[DW-1:W-1];
        end
        if (sat)
        begin
            det_next_out = neg_reg ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            det_next_out = neg_reg ? (W'(0) - rnd_lo) : rnd_lo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load[5])
        begin
            det_out_reg <= det_next_out;
            det_sat_reg <= sat;
        end
    end

    assign det_out = $signed(det_out_reg);
    assign det_sat = det_sat_reg;

endmodule

### rtl/tinv_j2.sv
// Trace and J2 datapath: trace/3, deviatoric diagonal, sum of squares, rounding.
module tinv_j2 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                          clk,
    input  tinv_pkg::tinv_adv_t           adv,
    input  logic signed [DATA_WIDTH-1:0]  a00,
    input  logic signed [DATA_WIDTH-1:0]  a01,
    input  logic signed [DATA_WIDTH-1:0]  a02,
    input  logic signed [DATA_WIDTH-1:0]  a10,
    input  logic signed [DATA_WIDTH-1:0]  a11,
    input  logic signed [DATA_WIDTH-1:0]  a12,
    input  logic signed [DATA_WIDTH-1:0]  a20,
    input  logic signed [DATA_WIDTH-1:0]  a21,
    input  logic signed [DATA_WIDTH-1:0]  a22,
    output logic signed [DATA_WIDTH-1:0]  trace_out,
    output logic [DATA_WIDTH-2:0]         j2_out,
    output logic                          trace_sat,
    output logic                          j2_sat
);
    import tinv_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int TW  = W + 2;          // unsaturated trace
    localparam int XW  = W + 1;          // |trace| + 1
    localparam int K   = W + 2;          // reciprocal scale
    localparam int QPW = 2 * XW;         // reciprocal product
    localparam int PW  = 2 * W;          // off-diagonal square
    localparam int DDW = W + 2;          // deviatoric diagonal element
    localparam int DSW = 2 * DDW;        // its square
    localparam int SQW = 2 * W + 5;      // sum of all squares
    localparam logic [XW-1:0]  RECIP   = XW'(({1'b1, {K{1'b0}}} + 2) / 3);
    localparam logic [SQW-1:0] HALF    = SQW'(1) << FRAC_BITS;
    localparam logic [W-1:0]   MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MIN_VAL = {1'b1, {(W-1){1'b0}}};

    // Stage 0: trace, |trace| + 1 for the divide by three, off-diagonal squares.
    logic signed [TW-1:0] tr_next;
    logic [XW-1:0]        x1_next;
    logic signed [W-1:0]  offd [6];

    always_comb
    begin
        tr_next = TW'(a00) + TW'(a11) + TW'(a22);
        x1_next = tr_next[TW-1] ? XW'(~tr_next + TW'(2)) : XW'(tr_next + TW'(1));
        offd[0] = a01;
        offd[1] = a02;
        offd[2] = a10;
        offd[3] = a12;
        offd[4] = a20;
        offd[5] = a21;
    end

    logic signed [TW-1:0] tr_s0_reg;
    logic [XW-1:0]        x1_reg;
    logic                 neg_s0_reg;
    logic [PW-1:0]        sqo_reg [6];
    logic signed [W-1:0]  dg_s0_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            tr_s0_reg    <= tr_next;
            x1_reg       <= x1_next;
            neg_s0_reg   <= tr_next[TW-1];
            dg_s0_reg[0] <= a00;
            dg_s0_reg[1] <= a11;
            dg_s0_reg[2] <= a22;
            for (int i = 0; i < 6; i++)
            begin
                sqo_reg[i] <= $unsigned(PW'(offd[i]) * PW'(offd[i]));
            end
        end
    end

    // Stage 1: floor((|trace| + 1) / 3) by reciprocal multiply; off-diagonal sum.
    logic [QPW-1:0] qprod;
    logic [SQW-1:0] offsum_next;

    always_comb
    begin
        qprod       = QPW'(x1_reg) * QPW'(RECIP);
        offsum_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            offsum_next = offsum_next + SQW'(sqo_reg[i]);
        end
    end

    logic signed [TW-1:0] tr_s1_reg;
    logic [W-1:0]         q_reg;
    logic                 neg_s1_reg;
    logic [SQW-1:0]       offsum_s1_reg;
    logic signed [W-1:0]  dg_s1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv.load[1])
        begin
            tr_s1_reg     <= tr_s0_reg;
            q_reg         <= qprod[K +: W];
            neg_s1_reg    <= neg_s0_reg;
            offsum_s1_reg <= offsum_next;
            dg_s1_reg     <= dg_s0_reg;
        end
    end

    // Stage 2: signed trace/3 and the deviatoric diagonal.
    logic signed [W:0] t3;

    always_comb
    begin
        t3 = neg_s1_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    logic signed [TW-1:0]  tr_s2_reg;
    logic [SQW-1:0]        offsum_s2_reg;
    logic signed [DDW-1:0] dev_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv.load[2])
        begin
            tr_s2_reg     <= tr_s1_reg;
            offsum_s2_reg <= offsum_s1_reg;
            for (int i = 0; i < 3; i++)
            begin
                dev_reg[i] <= DDW'(dg_s1_reg[i]) - DDW'(t3);
            end
        end
    end

    // Stage 3: squares of the deviatoric diagonal.
    logic signed [TW-1:0] tr_s3_reg;
    logic [SQW-1:0]       offsum_s3_reg;
    logic [DSW-1:0]       sqd_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv.load[3])
        begin
            tr_s3_reg     <= tr_s2_reg;
            offsum_s3_reg <= offsum_s2_reg;
            for (int i = 0; i < 3; i++)
            begin
                sqd_reg[i] <= $unsigned(DSW'(dev_reg[i]) * DSW'(dev_reg[i]));
            end
        end
    end

    // Stage 4: full double contraction.
    logic signed [TW-1:0] tr_s4_reg;
    logic [SQW-1:0]       ssum_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load[4])
        begin
            tr_s4_reg <= tr_s3_reg;
            ssum_reg  <= offsum_s3_reg + SQW'(sqd_reg[0]) + SQW'(sqd_reg[1])
                         + SQW'(sqd_reg[2]);
        end
    end

    // Stage 5: halve and round J2, saturate J2 and the trace.
    logic [SQW-1:0] j2_rnd;
    logic           j2_sat_next;
    logic           tr_sat_next;
    logic [W-2:0]   j2_next;
    logic [W-1:0]   tr_out_next;

    always_comb
    begin
        j2_rnd      = (ssum_reg + HALF) >> (FRAC_BITS + 1);
        j2_sat_next = |j2_rnd[SQW-1:W-1];
        j2_next     = j2_sat_next ? {(W-1){1'b1}} : j2_rnd[W-2:0];
        tr_sat_next = !((&tr_s4_reg[TW-1:W-1]) || (~|tr_s4_reg[TW-1:W-1]));
        if (tr_sat_next)
        begin
            tr_out_next = tr_s4_reg[TW-1] ? MIN_VAL : MAX_VAL;
        end
        else
        begin
            tr_out_next = tr_s4_reg[W-1:0];
        end
    end

    logic [W-1:0] trace_out_reg;
    logic [W-2:0] j2_out_reg;
    logic         trace_sat_reg;
    logic         j2_sat_reg;

    always_ff @(posedge clk)
    begin
        if (adv.load[5])
        begin
            trace_out_reg <= tr_out_next;
            j2_out_reg    <= j2_next;
            trace_sat_reg <= tr_sat_next;
            j2_sat_reg    <= j2_sat_next;
        end
    end

    assign trace_out = $signed(trace_out_reg);
    assign j2_out    = j2_out_reg;
    assign trace_sat = trace_sat_reg;
    assign j2_sat    = j2_sat_reg;

endmodule

### rtl/tensor_invariants_3x3_top.sv
// Top level of the 3x3 tensor invariants pipeline (trace, determinant, J2).
//
// Each transaction carries one 3x3 tensor of signed fixed-point elements in
// row-major order and yields one result: the saturated trace, the determinant
// rounded to the element format, and J2 of the deviatoric part, with overflow set
// when any of the three saturated. The block is a six-stage pipeline with a valid
// bit per stage: a tensor can be accepted every cycle when the output side does
// not stall. The depth is set by the determinant path, which chains two levels of
// word-sized multipliers and a wide sum before rounding. When the output stalls,
// empty stages still fill, so input is refused only once all six stages hold data.
module tensor_invariants_3x3_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [DATA_WIDTH-1:0]  a00,
    input  logic signed [DATA_WIDTH-1:0]  a01,
    input  logic signed [DATA_WIDTH-1:0]  a02,
    input  logic signed [DATA_WIDTH-1:0]  a10,
    input  logic signed [DATA_WIDTH-1:0]  a11,
    input  logic signed [DATA_WIDTH-1:0]  a12,
    input  logic signed [DATA_WIDTH-1:0]  a20,
    input  logic signed [DATA_WIDTH-1:0]  a21,
    input  logic signed [DATA_WIDTH-1:0]  a22,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [DATA_WIDTH-1:0]  trace_out,
    output logic signed [DATA_WIDTH-1:0]  det_out,
    output logic [DATA_WIDTH-2:0]         j2_out,
    output logic                          overflow
);
    import tinv_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-2:0] J2_MAX  = {(DATA_WIDTH-1){1'b1}};

    tinv_adv_t adv;
    logic      det_sat;
    logic      trace_sat;
    logic      j2_sat;

    // Stage valid bits and load strobes.
    tinv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .adv       (adv)
    );

    // Determinant datapath.
    tinv_det #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_det (
        .clk     (clk),
        .adv     (adv),
        .a00     (a00),
        .a01     (a01),
        .a02     (a02),
        .a10     (a10),
        .a11     (a11),
        .a12     (a12),
        .a20     (a20),
        .a21     (a21),
        .a22     (a22),
        .det_out (det_out),
        .det_sat (det_sat)
    );

    // Trace and J2 datapath.
    tinv_j2 #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_j2 (
        .clk       (clk),
        .adv       (adv),
        .a00       (a00),
        .a01       (a01),
        .a02       (a02),
        .a10       (a10),
        .a11       (a11),
        .a12       (a12),
        .a20       (a20),
        .a21       (a21),
        .a22       (a22),
        .trace_out (trace_out),
        .j2_out    (j2_out),
        .trace_sat (trace_sat),
        .j2_sat    (j2_sat)
    );

    // Any saturated result raises the overflow flag.
    assign overflow = det_sat | trace_sat | j2_sat;

    // An empty output stage means every stage can take data.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("input refused while the output stage is empty");

    // A draining output lets the whole chain advance.
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("input refused while the output is being taken");

    // Overflow with trace and J2 in range must come from a clamped determinant.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow && trace_out != MAX_VAL && trace_out != MIN_VAL
        && j2_out != J2_MAX |-> det_out == MAX_VAL || det_out == MIN_VAL)
        else $error("overflow set without any clamped result");

    // No result at its limit means no overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && trace_out != MAX_VAL && trace_out != MIN_VAL
        && det_out != MAX_VAL && det_out != MIN_VAL && j2_out != J2_MAX |-> !overflow)
        else $error("overflow set on an unclamped result");

endmodule
